>>> src/lru_kvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lru_kvc_pkg;

    // Request operation codes
    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // Value returned by a get that misses
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Capacity register
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // Update command from the request stage to the entry store
    typedef struct packed
    {
        logic en;           // rank update on the selected slot
        logic write_key;    // load the key into the selected slot
        logic write_value;  // load the value into the selected slot
        logic grow;         // slot becomes valid, entry count goes up
    } upd_t;

endpackage

`default_nettype wire

>>> src/lru_kvc_top.sv
// LRU key-value cache, top level.
// Request channel (req_valid / req_stall, fields op, key, value) carries get
// and put beats; response channel (rsp_valid / rsp_stall, fields hit,
// read_value) returns one beat per get, none per put.
// Throughput: one request beat per cycle while req_stall is low. A request
// is registered at acceptance in the request register and handled from there;
// a get's response beat is then registered in the response register, which
// drives rsp_valid. Handling is a combinational pass of the parallel key
// compare and rank update over the entry registers.
// A later request always sees the store as left by the earlier one.
// Stall: while the response register holds an untaken beat and rsp_stall is
// high, a pending get waits in the request register and req_stall rises;
// puts keep flowing since they produce no beat.
// Reset: all entries invalid, entry count zero, capacity 16; no clearing
// pass, the block takes requests right after reset.
// The user writes capacity (cfg_wr_en / cfg_wr_data) only while the block is
// idle; not enforced by the block. Zero acts as one, above ENTRIES as ENTRIES.
// Depends on lru_kvc_pkg, lru_kvc_lookup and lru_kvc_store.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_top
    import lru_kvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [CAP_W-1:0]   cfg_wr_data,
    // request channel
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic               op,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] value,
    // response channel
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic                    hit,
    output logic signed [31:0]      read_value
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] MAX_CAP = CMP_W'(ENTRIES);

    // Capacity register
    logic [CAP_W-1:0]  cap_reg;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  eff_cap;

    // Request register
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [31:0]       s1_key_reg;
    logic [31:0]       s1_value_reg;

    // Response register
    logic              rsp_valid_reg;
    logic              rsp_hit_reg;
    logic [31:0]       rsp_value_reg;
    logic              rsp_load;
    logic              rsp_hit_next;
    logic [31:0]       rsp_value_next;

    // Store and lookup
    logic [31:0]        entry_key   [ENTRIES];
    logic [31:0]        entry_value [ENTRIES];
    logic [ENTRIES-1:0] entry_valid;
    logic [RANK_W-1:0]  entry_rank  [ENTRIES];
    logic [CNT_W-1:0]   count;
    logic [ENTRIES-1:0] match_oh;
    logic [ENTRIES-1:0] oldest_oh;
    logic [ENTRIES-1:0] free_oh;
    logic [31:0]        hit_value;
    logic [RANK_W-1:0]  hit_rank;
    logic               key_hit;
    logic               has_room;

    // Update command
    upd_t               upd;
    logic [ENTRIES-1:0] slot_oh;
    logic [CNT_W-1:0]   thresh;

    // Handshake
    logic               out_free;
    logic               s1_go;
    logic               req_take;

    // Capacity clamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign cap_ext = CMP_W'(cap_reg);

    always_comb
    begin
        eff_cap = cap_ext;
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > MAX_CAP)
        begin
            eff_cap = MAX_CAP;
        end
    end

    // Flow control
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign s1_go     = s1_valid_reg && ((s1_op_reg == OP_PUT) || out_free);
    assign req_stall = s1_valid_reg && !s1_go;
    assign req_take  = req_valid && !req_stall;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_op_reg    <= op_t'(op);
            s1_key_reg   <= key;
            s1_value_reg <= value;
        end
    end

    // Entry store
    lru_kvc_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (upd),
        .slot_oh     (slot_oh),
        .thresh      (thresh),
        .new_key     (s1_key_reg),
        .new_value   (s1_value_reg),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .entry_valid (entry_valid),
        .entry_rank  (entry_rank),
        .count       (count)
    );

    // Key compare
    lru_kvc_lookup #(
        .ENTRIES (ENTRIES)
    ) u_lookup (
        .key         (s1_key_reg),
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .entry_valid (entry_valid),
        .entry_rank  (entry_rank),
        .count       (count),
        .match_oh    (match_oh),
        .oldest_oh   (oldest_oh),
        .hit_value   (hit_value),
        .hit_rank    (hit_rank)
    );

    // Slots fill in order and never empty, so the first free slot is at count
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            free_oh[i] = (count == CNT_W'(i));
        end
    end

    assign key_hit  = |match_oh;
    assign has_room = CMP_W'(count) < eff_cap;

    // Request decode
    always_comb
    begin
        upd            = '0;
        slot_oh        = '0;
        thresh         = '0;
        rsp_load       = 1'b0;
        rsp_hit_next   = 1'b0;
        rsp_value_next = MISS_VALUE;
        if (s1_go)
        begin
            case (s1_op_reg)
                OP_GET:
                begin
                    rsp_load = 1'b1;
                    if (key_hit)
                    begin
                        upd.en         = 1'b1;
                        slot_oh        = match_oh;
                        thresh         = CNT_W'(hit_rank);
                        rsp_hit_next   = 1'b1;
                        rsp_value_next = hit_value;
                    end
                end
                OP_PUT:
                begin
                    upd.en          = 1'b1;
                    upd.write_value = 1'b1;
                    if (key_hit)
                    begin
                        // update in place
                        slot_oh = match_oh;
                        thresh  = CNT_W'(hit_rank);
                    end
                    else if (has_room)
                    begin
                        // insert into a free slot, every valid entry ages
                        upd.write_key = 1'b1;
                        upd.grow      = 1'b1;
                        slot_oh       = free_oh;
                        thresh        = count;
                    end
                    else
                    begin
                        // replace the least recent entry
                        upd.write_key = 1'b1;
                        slot_oh       = oldest_oh;
                        thresh        = count - CNT_W'(1);
                    end
                end
                default:
                begin
                    upd = '0;
                end
            endcase
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_hit_reg   <= rsp_hit_next;
            rsp_value_reg <= rsp_value_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign hit        = rsp_hit_reg;
    assign read_value = rsp_value_reg;

endmodule

`default_nettype wire

>>> src/lru_kvc_lookup.sv
// Parallel key compare and one-hot readout over all entries.
// Depends on lru_kvc_pkg; feeds the request stage in the top level.
`timescale 1ns / 1ps
`default_nettype none

module lru_kvc_lookup
    import lru_kvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic [31:0]                                key,
    input  wire logic [31:0]                                entry_key [ENTRIES],
    input  wire logic [31:0]                                entry_value [ENTRIES],
    input  wire logic [ENTRIES-1:0]                         entry_valid,
    input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] entry_rank [ENTRIES],
    input  wire logic [$clog2(ENTRIES+1)-1:0]               count,
    output logic      [ENTRIES-1:0]                         match_oh,
    output logic      [ENTRIES-1:0]                         oldest_oh,
    output logic      [31:0]                                hit_value,
    output logic      [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_rank
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0] last_rank;

    // Least recent entry holds rank count-1 (ranks are distinct)
    assign last_rank = count - CNT_W'(1);

    // Per-entry compare
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_oh[i]  = entry_valid[i] && (entry_key[i] == key);
            oldest_oh[i] = entry_valid[i] && (CNT_W'(entry_rank[i]) == last_rank);
        end
    end

    // AND-OR readout of the matching entry
    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_value = hit_value | ({32{match_oh[i]}} & entry_value[i]);
            hit_rank  = hit_rank  | ({RANK_W{match_oh[i]}} & entry_rank[i]);
        end
    end

endmodule

`default_nettype wire

>>> src/lru_kvc_store.sv
// Entry registers: keys, values, valid marks, recency ranks, entry count.
// Depends on lru_kvc_pkg; driven by the request stage in the top level.
`timescale 1ns / 1ps
`default_nettype none

module lru_kvc_store
    import lru_kvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire upd_t                                       upd,
    input  wire logic [ENTRIES-1:0]                         slot_oh,
    input  wire logic [$clog2(ENTRIES+1)-1:0]               thresh,
    input  wire logic [31:0]                                new_key,
    input  wire logic [31:0]                                new_value,
    output logic      [31:0]                                entry_key [ENTRIES],
    output logic      [31:0]                                entry_value [ENTRIES],
    output logic      [ENTRIES-1:0]                         entry_valid,
    output logic      [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] entry_rank [ENTRIES],
    output logic      [$clog2(ENTRIES+1)-1:0]               count
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    logic [31:0]        key_reg   [ENTRIES];
    logic [31:0]        value_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Rank update: selected slot goes to zero, younger valid entries age by one
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (upd.en)
            begin
                if (slot_oh[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (CNT_W'(rank_reg[i]) < thresh))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
    end

    // Fill: new slot becomes valid
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (upd.grow)
        begin
            valid_next = valid_reg | slot_oh;
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_oh[i] && upd.write_key)
            begin
                key_reg[i] <= new_key;
            end
            if (slot_oh[i] && upd.write_value)
            begin
                value_reg[i] <= new_value;
            end
        end
    end

    assign entry_key   = key_reg;
    assign entry_value = value_reg;
    assign entry_valid = valid_reg;
    assign entry_rank  = rank_reg;
    assign count       = count_reg;

endmodule

`default_nettype wire
